@@ rtl/core/vcac_pkg.sv @@
// Package for the voice capture arming controller.
// Holds the event, command and register codes, protocol constants and shared structs.
// No dependencies.
package vcac_pkg;

  localparam int unsigned TimeW = 48;
  localparam int unsigned NowW  = 47;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgDataW = 16;

  localparam logic [15:0] CodeStart = 16'h800A;
  localparam logic [15:0] CodeStop  = 16'h800D;
  localparam logic [15:0] CodeKey   = 16'h808B;
  localparam logic [10:0] VoiceLen  = 11'd124;
  localparam logic [10:0] MotionLen = 11'd20;
  localparam logic [4:0]  RetryMax  = 5'd31;

  localparam logic [CfgIdxW-1:0] RegArmPolicy  = 3'd0;
  localparam logic [CfgIdxW-1:0] RegTailMs     = 3'd1;
  localparam logic [CfgIdxW-1:0] RegSilenceMs  = 3'd2;
  localparam logic [CfgIdxW-1:0] RegRearmMs    = 3'd3;
  localparam logic [CfgIdxW-1:0] RegRetryLimit = 3'd4;
  localparam logic [CfgIdxW-1:0] RegBackoffMs  = 3'd5;

  typedef enum logic [1:0] {
    ModeTick     = 2'd0,
    ModeVoice    = 2'd1,
    ModeMotion   = 2'd2,
    ModeConsumer = 2'd3
  } mode_e;

  typedef enum logic [1:0] {
    CmdNone    = 2'd0,
    CmdStart   = 2'd1,
    CmdStop    = 2'd2,
    CmdRestart = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    PolicyButton   = 2'd0,
    PolicyConsumer = 2'd1,
    PolicyAlways   = 2'd2,
    PolicyButtonAlt = 2'd3
  } policy_e;

  typedef struct packed {
    policy_e     arm_policy;
    logic [15:0] tail_ms;
    logic [15:0] silence_ms;
    logic [15:0] rearm_ms;
    logic [3:0]  retry_limit;
    logic [15:0] backoff_ms;
  } cfg_t;

  typedef struct packed {
    logic             armed;
    logic             streaming;
    logic             consumer_on;
    logic [4:0]       retries;
    logic [TimeW-1:0] button_deadline;
    logic [TimeW-1:0] backoff_deadline;
    logic [TimeW-1:0] audio_stamp;
    logic [TimeW-1:0] cmd_stamp;
  } state_t;

  typedef struct packed {
    mode_e           mode;
    logic [NowW-1:0] now_ms;
    logic [10:0]     report_length;
    logic [15:0]     event_code;
    logic            consumer_streaming;
  } item_t;

  typedef struct packed {
    cmd_e       command;
    logic       is_armed;
    logic       is_streaming;
    logic [4:0] retry_count;
    logic       gave_up;
  } result_t;

endpackage

@@ rtl/core/vcac_cfg_regs.sv @@
// Configuration register file of the voice capture arming controller.
// Depends on vcac_pkg for the register indexes and the cfg_t struct.
module vcac_cfg_regs
  import vcac_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  output cfg_t                cfg_o
);

  cfg_t cfg_q, cfg_d;

  assign cfg_ready_o = 1'b1;
  assign cfg_o = cfg_q;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      unique case (cfg_index_i)
        RegArmPolicy:  cfg_d.arm_policy  = policy_e'(cfg_data_i[1:0]);
        RegTailMs:     cfg_d.tail_ms     = cfg_data_i;
        RegSilenceMs:  cfg_d.silence_ms  = cfg_data_i;
        RegRearmMs:    cfg_d.rearm_ms    = cfg_data_i;
        RegRetryLimit: cfg_d.retry_limit = cfg_data_i[3:0];
        RegBackoffMs:  cfg_d.backoff_ms  = cfg_data_i;
        default:       cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.arm_policy  <= PolicyButton;
      cfg_q.tail_ms     <= 16'd1500;
      cfg_q.silence_ms  <= 16'd1000;
      cfg_q.rearm_ms    <= 16'd4000;
      cfg_q.retry_limit <= 4'd3;
      cfg_q.backoff_ms  <= 16'd5000;
    end else begin
      cfg_q <= cfg_d;
    end
  end

endmodule

@@ rtl/core/vcac_step.sv @@
// Combinational event logic of the voice capture arming controller.
// Computes the next state and the result for one event; depends on vcac_pkg.
module vcac_step
  import vcac_pkg::*;
(
  input  cfg_t    cfg_i,
  input  state_t  state_i,
  input  item_t   item_i,
  output state_t  state_o,
  output result_t result_o
);

  logic [TimeW-1:0] now;
  logic             want;
  logic             silent;
  logic             idle;
  logic [TimeW-1:0] audio_diff;
  logic [TimeW-1:0] cmd_diff;
  cmd_e             cmd;
  logic             gave;

  assign now        = {1'b0, item_i.now_ms};
  assign audio_diff = now - state_i.audio_stamp;
  assign cmd_diff   = now - state_i.cmd_stamp;
  assign silent = (now > state_i.audio_stamp) &&
                  (audio_diff > {{(TimeW-16){1'b0}}, cfg_i.silence_ms});
  assign idle   = (now > state_i.cmd_stamp) &&
                  (cmd_diff > {{(TimeW-16){1'b0}}, cfg_i.rearm_ms});

  always_comb begin
    unique case (cfg_i.arm_policy)
      PolicyAlways:   want = 1'b1;
      PolicyConsumer: want = state_i.consumer_on;
      default:        want = now < state_i.button_deadline;
    endcase
  end

  always_comb begin
    state_o = state_i;
    cmd     = CmdNone;
    gave    = 1'b0;
    unique case (item_i.mode)
      ModeTick: begin
        if (want && !state_i.armed) begin
          if (now >= state_i.backoff_deadline) begin
            state_o.armed       = 1'b1;
            state_o.audio_stamp = now;
            state_o.cmd_stamp   = now;
            cmd                 = CmdStart;
          end
        end else if (!want && state_i.armed) begin
          state_o.armed     = 1'b0;
          state_o.streaming = 1'b0;
          state_o.retries   = '0;
          state_o.cmd_stamp = now;
          cmd               = CmdStop;
        end else if (state_i.armed) begin
          if (silent) begin
            if (state_i.retries >= {1'b0, cfg_i.retry_limit}) begin
              gave                     = 1'b1;
              state_o.button_deadline  = '0;
              state_o.backoff_deadline = now + {{(TimeW-16){1'b0}}, cfg_i.backoff_ms};
              state_o.armed            = 1'b0;
              state_o.streaming        = 1'b0;
              state_o.retries          = '0;
              state_o.cmd_stamp        = now;
              cmd                      = CmdStop;
            end else begin
              if (state_i.retries < RetryMax) begin
                state_o.retries = state_i.retries + 5'd1;
              end
              state_o.streaming   = 1'b0;
              state_o.audio_stamp = now;
              state_o.cmd_stamp   = now;
              cmd                 = CmdStart;
            end
          end else if (idle) begin
            state_o.cmd_stamp = now;
            cmd               = CmdRestart;
          end
        end
      end
      ModeVoice: begin
        if (item_i.report_length == VoiceLen) begin
          state_o.audio_stamp = now;
          state_o.retries     = '0;
          if (item_i.event_code == CodeStart) begin
            state_o.streaming = 1'b1;
          end else if (item_i.event_code == CodeStop) begin
            state_o.streaming = 1'b0;
          end
        end
      end
      ModeMotion: begin
        if (item_i.report_length == MotionLen) begin
          if (item_i.event_code == CodeKey) begin
            state_o.button_deadline = now + {{(TimeW-16){1'b0}}, cfg_i.tail_ms};
          end else if (item_i.event_code == CodeStart) begin
            state_o.streaming = 1'b1;
          end else if (item_i.event_code == CodeStop) begin
            state_o.streaming = 1'b0;
          end
        end
      end
      default: begin
        state_o.consumer_on = item_i.consumer_streaming;
      end
    endcase
  end

  assign result_o.command      = cmd;
  assign result_o.is_armed     = state_o.armed;
  assign result_o.is_streaming = state_o.streaming;
  assign result_o.retry_count  = state_o.retries;
  assign result_o.gave_up      = gave;

endmodule

@@ rtl/core/voice_capture_arming_controller.sv @@
// Top level of the voice capture arming controller.
// Holds the input register, the controller state and the result register;
// depends on vcac_pkg, vcac_cfg_regs and vcac_step.
//
// Usage: events enter on the input channel (in_valid_i / in_ready_o) with
// their kind, millisecond timestamp, report length, report code and consumer
// state. Each event yields exactly one result on the output channel
// (out_valid_o / out_ready_i): the command to send, the armed and streaming
// flags, the retry count and a gave-up flag. Registers are written through
// the configuration channel (cfg_valid_i / cfg_ready_o) while no event is in
// flight; cfg_ready_o is always high and unknown indexes are ignored.
// An event is captured in the input register, decided by the combinational
// event logic and presented from the result register; while the receiver
// does not stall, one event per cycle is taken.
// When the receiver stalls, the result register holds and in_ready_o drops
// as soon as the input register holds an event.
// Reset clears all flags, the retry count and all stored times to zero and
// loads the register reset values.
module voice_capture_arming_controller
  import vcac_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [1:0]          mode_i,
  input  logic [NowW-1:0]     now_ms_i,
  input  logic [10:0]         report_length_i,
  input  logic [15:0]         event_code_i,
  input  logic                consumer_streaming_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [1:0]          command_o,
  output logic                is_armed_o,
  output logic                is_streaming_o,
  output logic [4:0]          retry_count_o,
  output logic                gave_up_o
);

  cfg_t    cfg;
  item_t   item_q;
  logic    item_valid_q;
  state_t  state_q, state_d;
  result_t result_q, result_d;
  logic    out_valid_q;
  logic    advance;

  vcac_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  vcac_step u_step (
    .cfg_i    (cfg),
    .state_i  (state_q),
    .item_i   (item_q),
    .state_o  (state_d),
    .result_o (result_d)
  );

  assign advance    = item_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !item_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      item_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
      state_q      <= '0;
    end else begin
      if (in_ready_o) begin
        item_valid_q <= in_valid_i;
      end
      if (advance) begin
        out_valid_q <= 1'b1;
        state_q     <= state_d;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      item_q.mode               <= mode_e'(mode_i);
      item_q.now_ms             <= now_ms_i;
      item_q.report_length      <= report_length_i;
      item_q.event_code         <= event_code_i;
      item_q.consumer_streaming <= consumer_streaming_i;
    end
    if (advance) begin
      result_q <= result_d;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign command_o      = result_q.command;
  assign is_armed_o     = result_q.is_armed;
  assign is_streaming_o = result_q.is_streaming;
  assign retry_count_o  = result_q.retry_count;
  assign gave_up_o      = result_q.gave_up;

endmodule

@@ test/tb_voice_capture_arming_controller.sv @@
// Self-checking testbench for voice_capture_arming_controller.
// Drives events and register writes, predicts every result and compares it
// field by field; depends only on vcac_pkg and the controller itself.
module tb_voice_capture_arming_controller;
  timeunit 1ns;
  timeprecision 1ps;

  import vcac_pkg::*;

  localparam int unsigned CycleLimit = 400000;
  localparam logic [NowW-1:0] MaxNow = '1;

  logic                clk_i;
  logic                rst_ni;
  logic                cfg_valid_i;
  logic                cfg_ready_o;
  logic [CfgIdxW-1:0]  cfg_index_i;
  logic [CfgDataW-1:0] cfg_data_i;
  logic                in_valid_i;
  logic                in_ready_o;
  logic [1:0]          mode_i;
  logic [NowW-1:0]     now_ms_i;
  logic [10:0]         report_length_i;
  logic [15:0]         event_code_i;
  logic                consumer_streaming_i;
  logic                out_valid_o;
  logic                out_ready_i;
  logic [1:0]          command_o;
  logic                is_armed_o;
  logic                is_streaming_o;
  logic [4:0]          retry_count_o;
  logic                gave_up_o;

  voice_capture_arming_controller uut (.*);

  cfg_t             cfg_q;
  logic             armed_q;
  logic             streaming_q;
  logic             consumer_on_q;
  logic [4:0]       retries_q;
  logic [TimeW-1:0] key_deadline_q;
  logic [TimeW-1:0] backoff_until_q;
  logic [TimeW-1:0] audio_time_q;
  logic [TimeW-1:0] cmd_time_q;

  result_t         arm_status_q[$];
  logic [NowW-1:0] clock_ms;
  int unsigned     send_idle_pct;
  int unsigned     recv_idle_pct;
  int unsigned     hold_left;
  int unsigned     cycles;
  int unsigned     mismatches;
  int unsigned     events_sent;
  int unsigned     reg_writes;
  int unsigned     start_cnt;
  int unsigned     stop_cnt;
  int unsigned     restart_cnt;
  int unsigned     giveup_cnt;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    while (cycles < CycleLimit) begin
      @(posedge clk_i);
      cycles++;
    end
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin
    out_ready_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_left > 0) begin
        out_ready_i = 1'b0;
        hold_left--;
      end else begin
        out_ready_i = ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  function automatic logic [TimeW-1:0] since(input logic [TimeW-1:0] now,
                                             input logic [TimeW-1:0] then_ms);
    return (now > then_ms) ? now - then_ms : '0;
  endfunction

  task automatic decide_tick(input logic [TimeW-1:0] now, output cmd_e cmd,
                             output logic gave);
    logic want;
    cmd = CmdNone;
    gave = 1'b0;
    case (cfg_q.arm_policy)
      PolicyAlways:   want = 1'b1;
      PolicyConsumer: want = consumer_on_q;
      default:        want = (now < key_deadline_q);
    endcase
    if (want && !armed_q) begin
      if (now >= backoff_until_q) begin
        armed_q = 1'b1;
        audio_time_q = now;
        cmd_time_q = now;
        cmd = CmdStart;
      end
    end else if (!want && armed_q) begin
      armed_q = 1'b0;
      streaming_q = 1'b0;
      retries_q = '0;
      cmd_time_q = now;
      cmd = CmdStop;
    end else if (armed_q) begin
      if (since(now, audio_time_q) > cfg_q.silence_ms) begin
        if (retries_q >= cfg_q.retry_limit) begin
          gave = 1'b1;
          key_deadline_q = '0;
          backoff_until_q = now + cfg_q.backoff_ms;
          armed_q = 1'b0;
          streaming_q = 1'b0;
          retries_q = '0;
          cmd_time_q = now;
          cmd = CmdStop;
        end else begin
          if (retries_q < RetryMax) retries_q = retries_q + 5'd1;
          streaming_q = 1'b0;
          audio_time_q = now;
          cmd_time_q = now;
          cmd = CmdStart;
        end
      end else if (since(now, cmd_time_q) > cfg_q.rearm_ms) begin
        cmd_time_q = now;
        cmd = CmdRestart;
      end
    end
  endtask

  task automatic advance_arming(input item_t it, output result_t res);
    logic [TimeW-1:0] now;
    cmd_e cmd;
    logic gave;
    now = {1'b0, it.now_ms};
    cmd = CmdNone;
    gave = 1'b0;
    case (it.mode)
      ModeTick: decide_tick(now, cmd, gave);
      ModeVoice: begin
        if (it.report_length == VoiceLen) begin
          audio_time_q = now;
          retries_q = '0;
          if (it.event_code == CodeStart && !streaming_q) streaming_q = 1'b1;
          else if (it.event_code == CodeStop) streaming_q = 1'b0;
        end
      end
      ModeMotion: begin
        if (it.report_length == MotionLen) begin
          if (it.event_code == CodeKey) key_deadline_q = now + cfg_q.tail_ms;
          else if (it.event_code == CodeStart) streaming_q = 1'b1;
          else if (it.event_code == CodeStop) streaming_q = 1'b0;
        end
      end
      default: consumer_on_q = it.consumer_streaming;
    endcase
    res.command = cmd;
    res.is_armed = armed_q;
    res.is_streaming = streaming_q;
    res.retry_count = retries_q;
    res.gave_up = gave;
  endtask

  task automatic check_field(input string name, input logic [4:0] want,
                             input logic [4:0] got);
    if (want !== got) begin
      $error("%s expected %0d actual %0d", name, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk_i) begin : check_results
    result_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (arm_status_q.size() == 0) begin
        $error("result transfer with no expected result pending");
        mismatches++;
      end else begin
        want = arm_status_q.pop_front();
        check_field("command", 5'(want.command), 5'(command_o));
        check_field("is_armed", 5'(want.is_armed), 5'(is_armed_o));
        check_field("is_streaming", 5'(want.is_streaming), 5'(is_streaming_o));
        check_field("retry_count", want.retry_count, retry_count_o);
        check_field("gave_up", 5'(want.gave_up), 5'(gave_up_o));
        case (want.command)
          CmdStart:   start_cnt++;
          CmdStop:    stop_cnt++;
          CmdRestart: restart_cnt++;
          default: ;
        endcase
        if (want.gave_up) giveup_cnt++;
      end
    end
  end

  task automatic send_event(input item_t it);
    result_t res;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i = 1'b0;
      @(negedge clk_i);
    end
    in_valid_i = 1'b1;
    mode_i = it.mode;
    now_ms_i = it.now_ms;
    report_length_i = it.report_length;
    event_code_i = it.event_code;
    consumer_streaming_i = it.consumer_streaming;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    advance_arming(it, res);
    arm_status_q.push_back(res);
    events_sent++;
    @(negedge clk_i);
  endtask

  task automatic quiesce();
    in_valid_i = 1'b0;
    while (arm_status_q.size() != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] data);
    cfg_valid_i = 1'b1;
    cfg_index_i = idx;
    cfg_data_i = data;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    case (idx)
      RegArmPolicy:  cfg_q.arm_policy = policy_e'(data[1:0]);
      RegTailMs:     cfg_q.tail_ms = data;
      RegSilenceMs:  cfg_q.silence_ms = data;
      RegRearmMs:    cfg_q.rearm_ms = data;
      RegRetryLimit: cfg_q.retry_limit = data[3:0];
      RegBackoffMs:  cfg_q.backoff_ms = data;
      default: ;
    endcase
    reg_writes++;
    @(negedge clk_i);
  endtask

  task automatic apply_config(input cfg_t c);
    write_reg(RegArmPolicy, {14'($urandom), c.arm_policy});
    write_reg(RegTailMs, c.tail_ms);
    write_reg(RegSilenceMs, c.silence_ms);
    write_reg(RegRearmMs, c.rearm_ms);
    write_reg(RegRetryLimit, {12'($urandom), c.retry_limit});
    write_reg(RegBackoffMs, c.backoff_ms);
    cfg_valid_i = 1'b0;
  endtask

  function automatic cfg_t make_cfg(input policy_e p, input logic [15:0] tail,
                                    input logic [15:0] silence, input logic [15:0] rearm,
                                    input logic [3:0] retry, input logic [15:0] backoff);
    cfg_t c;
    c.arm_policy = p;
    c.tail_ms = tail;
    c.silence_ms = silence;
    c.rearm_ms = rearm;
    c.retry_limit = retry;
    c.backoff_ms = backoff;
    return c;
  endfunction

  function automatic item_t mk_event(input mode_e m, input logic [NowW-1:0] t,
                                     input logic [10:0] len, input logic [15:0] code,
                                     input logic cs);
    item_t it;
    it.mode = m;
    it.now_ms = t;
    it.report_length = len;
    it.event_code = code;
    it.consumer_streaming = cs;
    return it;
  endfunction

  function automatic logic [15:0] pick_ms(input int unsigned hi);
    int unsigned r;
    r = $urandom_range(9);
    if (r == 0) return 16'd0;
    if (r == 1) return 16'hFFFF;
    return 16'($urandom_range(hi));
  endfunction

  function automatic item_t next_event();
    item_t it;
    int unsigned r;
    logic [63:0] wide;
    r = $urandom_range(99);
    wide = {$urandom, $urandom};
    if (r < 60) clock_ms = clock_ms + NowW'($urandom_range(300));
    else if (r < 85) clock_ms = clock_ms + NowW'($urandom_range(3000));
    else if (r < 95) clock_ms = clock_ms + NowW'($urandom_range(70000));
    else if (r < 97) clock_ms = clock_ms - NowW'($urandom_range(2000));
    else clock_ms = wide[NowW-1:0];
    r = $urandom_range(99);
    if (r < 45) it.mode = ModeTick;
    else if (r < 65) it.mode = ModeVoice;
    else if (r < 85) it.mode = ModeMotion;
    else it.mode = ModeConsumer;
    it.now_ms = clock_ms;
    it.report_length = 11'($urandom_range(1024));
    if ($urandom_range(99) < 85) begin
      if (it.mode == ModeVoice) it.report_length = VoiceLen;
      else if (it.mode == ModeMotion) it.report_length = MotionLen;
    end
    case ($urandom_range(4))
      0, 1:    it.event_code = CodeStart;
      2:       it.event_code = CodeStop;
      3:       it.event_code = CodeKey;
      default: it.event_code = 16'($urandom);
    endcase
    it.consumer_streaming = 1'($urandom_range(1));
    return it;
  endfunction

  task automatic test_button_policy();
    send_idle_pct = 0;
    recv_idle_pct = 30;
    send_event(mk_event(ModeTick, 47'd0, 11'd0, 16'd0, 1'b0));
    send_event(mk_event(ModeMotion, 47'd100, MotionLen, CodeKey, 1'b0));
    send_event(mk_event(ModeTick, 47'd200, 11'd0, 16'd0, 1'b0));
    send_event(mk_event(ModeVoice, 47'd300, VoiceLen, CodeStart, 1'b0));
    send_event(mk_event(ModeVoice, 47'd310, 11'd123, CodeStop, 1'b0));
    send_event(mk_event(ModeVoice, 47'd400, VoiceLen, 16'h1234, 1'b0));
    send_event(mk_event(ModeTick, 47'd1500, 11'd0, 16'd0, 1'b0));
    send_event(mk_event(ModeTick, 47'd50, 11'd0, 16'd0, 1'b0));
    send_event(mk_event(ModeTick, 47'd2600, 11'd0, 16'd0, 1'b0));
    send_event(mk_event(ModeMotion, 47'd2700, MotionLen, CodeStart, 1'b0));
    send_event(mk_event(ModeMotion, 47'd2710, 11'd1024, CodeStop, 1'b0));
    send_event(mk_event(ModeMotion, 47'd2720, MotionLen, CodeStop, 1'b0));
    send_event(mk_event(ModeConsumer, 47'd2730, 11'd0, 16'hFFFF, 1'b1));
  endtask

  task automatic test_giveup_backoff();
    quiesce();
    apply_config(make_cfg(PolicyAlways, 16'd1500, 16'd0, 16'd4000, 4'd0, 16'd5000));
    send_event(mk_event(ModeTick, 47'd3000, 11'd0, 16'd0, 1'b0));
    send_event(mk_event(ModeTick, 47'd3001, 11'd0, 16'd0, 1'b0));
    send_event(mk_event(ModeTick, 47'd4000, 11'd0, 16'd0, 1'b0));
    send_event(mk_event(ModeTick, 47'd8001, 11'd0, 16'd0, 1'b0));
    send_event(mk_event(ModeTick, 47'd8002, 11'd0, 16'd0, 1'b0));
  endtask

  task automatic test_field_extremes();
    quiesce();
    write_reg(3'd6, 16'hFFFF);
    write_reg(3'd7, 16'h0000);
    apply_config(make_cfg(PolicyButtonAlt, 16'hFFFF, 16'hFFFF, 16'd0, 4'd15, 16'hFFFF));
    send_event(mk_event(ModeMotion, MaxNow - 47'd2, MotionLen, CodeKey, 1'b0));
    send_event(mk_event(ModeTick, MaxNow - 47'd1, 11'd0, 16'd0, 1'b0));
    send_event(mk_event(ModeTick, MaxNow, 11'h7FF & 11'd1024, 16'hFFFF, 1'b1));
    send_event(mk_event(ModeVoice, MaxNow, VoiceLen, 16'hFFFF, 1'b1));
    send_event(mk_event(ModeConsumer, MaxNow, 11'd1024, 16'd0, 1'b0));
    quiesce();
    apply_config(make_cfg(PolicyConsumer, 16'd0, 16'd0, 16'hFFFF, 4'd0, 16'd0));
    send_event(mk_event(ModeTick, MaxNow, 11'd0, 16'd0, 1'b0));
  endtask

  task automatic run_random_phase(input int unsigned send_pct, input int unsigned recv_pct);
    cfg_t c;
    int unsigned r;
    for (int seg = 0; seg < 5; seg++) begin
      quiesce();
      r = $urandom_range(9);
      c = make_cfg(policy_e'($urandom_range(3)), pick_ms(4000), pick_ms(2000),
                   pick_ms(5000), 4'($urandom_range(5)), pick_ms(8000));
      if (r < 2) c.retry_limit = 4'd0;
      else if (r < 4) c.retry_limit = 4'd15;
      apply_config(c);
      send_idle_pct = send_pct;
      recv_idle_pct = recv_pct;
      repeat (70) send_event(next_event());
    end
  endtask

  task automatic test_backpressure();
    quiesce();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_left = 150;
    repeat (30) send_event(next_event());
  endtask

  initial begin
    rst_ni = 1'b0;
    cfg_valid_i = 1'b0;
    cfg_index_i = '0;
    cfg_data_i = '0;
    in_valid_i = 1'b0;
    mode_i = '0;
    now_ms_i = '0;
    report_length_i = '0;
    event_code_i = '0;
    consumer_streaming_i = 1'b0;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_left = 0;
    cycles = 0;
    mismatches = 0;
    events_sent = 0;
    reg_writes = 0;
    start_cnt = 0;
    stop_cnt = 0;
    restart_cnt = 0;
    giveup_cnt = 0;
    clock_ms = 47'd20000;
    cfg_q = make_cfg(PolicyButton, 16'd1500, 16'd1000, 16'd4000, 4'd3, 16'd5000);
    armed_q = 1'b0;
    streaming_q = 1'b0;
    consumer_on_q = 1'b0;
    retries_q = '0;
    key_deadline_q = '0;
    backoff_until_q = '0;
    audio_time_q = '0;
    cmd_time_q = '0;
    repeat (12) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);
    test_button_policy();
    test_giveup_backoff();
    test_field_extremes();
    run_random_phase(18, 75);
    run_random_phase(75, 18);
    run_random_phase(0, 0);
    test_backpressure();
    quiesce();
    repeat (8) @(negedge clk_i);
    if (arm_status_q.size() != 0) begin
      $error("%0d expected results never arrived", arm_status_q.size());
      mismatches++;
    end
    $display("Run covered %0d events and %0d register writes over all arming policies.",
             events_sent, reg_writes);
    $display("Commands seen: %0d start, %0d stop, %0d restart; %0d give-ups.",
             start_cnt, stop_cnt, restart_cnt, giveup_cnt);
    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
